// ----- rtl/dxt_pkg.sv -----
// shared types, format codes and endpoint expansion for the block decoder
package dxt_pkg;

	localparam logic [1:0] FMT_DXT1 = 2'd0;
	localparam logic [1:0] FMT_DXT3 = 2'd1;
	localparam logic [1:0] FMT_DXT5 = 2'd2;
	localparam logic [1:0] FMT_NONE = 2'd3;

	localparam int QUEUE_DEPTH_DEF = 2;

	typedef struct packed {
		logic [63:0] block_low;
		logic [63:0] block_high;
		logic [2:0]  cols_valid;
		logic [2:0]  rows_valid;
	} dxt_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha_out;
		logic [1:0] texel_row;
		logic [1:0] texel_col;
		logic       last;
	} dxt_out_t;

	typedef struct packed {
		logic [1:0]       fmt;
		logic [1:0]       cols_m1;
		logic [1:0]       rows_m1;
		logic [3:0][23:0] pal_rgb;
		logic             transp3;
		logic [31:0]      codes;
		logic [63:0]      alo;
		logic [7:0][7:0]  atab;
	} dxt_job_t;

	// (v * 255 + 15) / 31 through a reciprocal multiply
	function automatic logic [7:0] exp5(input logic [4:0] v);
		logic [12:0] num;
		logic [26:0] prod;
		num  = 13'(v) * 13'd255 + 13'd15;
		prod = 27'(num) * 27'd8457;
		return prod[25:18];
	endfunction

	// (v * 255 + 31) / 63 through a reciprocal multiply
	function automatic logic [7:0] exp6(input logic [5:0] v);
		logic [13:0] num;
		logic [28:0] prod;
		num  = 14'(v) * 14'd255 + 14'd31;
		prod = 29'(num) * 29'd16645;
		return prod[27:20];
	endfunction

endpackage

// ----- rtl/dxt_front.sv -----
// front end: format register, block intake, classification and palette build
module dxt_front
	import dxt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dxt_in_t  blk,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [1:0] cfg_data,
	output logic     push,
	output dxt_job_t job,
	input  logic     q_full
);

	logic [1:0]  fmt_q;
	logic        v_s1, v_s2;
	logic [1:0]  fmt_s1, cols_m1_s1, rows_m1_s1;
	logic [63:0] lo_s1, hi_s1;
	logic [1:0]  fmt_s2, cols_m1_s2, rows_m1_s2;
	logic [63:0] lo_s2;
	logic [31:0] codes_s2;
	logic [23:0] e0_s2, e1_s2;
	logic        three_s2, six_s2;
	logic [2:0][9:0]  cn2_s2, cn3_s2;
	logic [5:0][10:0] an_s2;

	logic        accept, adv_s1, adv_s2, s2_free, good;
	logic [2:0]  cols_sat, rows_sat;
	logic [63:0] cblk;
	logic [15:0] first, second;
	logic [23:0] e0, e1;
	logic        three, six;
	logic [7:0]  a0, a1;
	logic [2:0][9:0]  cn2, cn3;
	logic [5:0][10:0] an;

	assign cfg_ready = 1'b1;
	assign adv_s2    = v_s2 && !q_full;
	assign s2_free   = !v_s2 || adv_s2;
	assign adv_s1    = v_s1 && s2_free;
	assign busy      = v_s1 && !s2_free;
	assign accept    = start && !busy;
	assign push      = adv_s2;

	assign cols_sat = (blk.cols_valid > 3'd4) ? 3'd4 : blk.cols_valid;
	assign rows_sat = (blk.rows_valid > 3'd4) ? 3'd4 : blk.rows_valid;
	assign good     = (fmt_q != FMT_NONE) && (cols_sat != 3'd0) && (rows_sat != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_DXT1;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fmt_q <= cfg_data;
			end
			if (accept) begin
				v_s1 <= good;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (adv_s2) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fmt_s1     <= fmt_q;
			lo_s1      <= blk.block_low;
			hi_s1      <= blk.block_high;
			cols_m1_s1 <= 2'(cols_sat - 3'd1);
			rows_m1_s1 <= 2'(rows_sat - 3'd1);
		end
	end

	always_comb begin
		cblk   = (fmt_s1 == FMT_DXT1) ? lo_s1 : hi_s1;
		first  = cblk[15:0];
		second = cblk[31:16];
		e0     = {exp5(first[15:11]), exp6(first[10:5]), exp5(first[4:0])};
		e1     = {exp5(second[15:11]), exp6(second[10:5]), exp5(second[4:0])};
		three  = (fmt_s1 == FMT_DXT1) && (first <= second);
		a0     = lo_s1[7:0];
		a1     = lo_s1[15:8];
		six    = a0 > a1;
		for (int ch = 0; ch < 3; ch++) begin
			if (three) begin
				cn2[ch] = 10'(e0[ch*8 +: 8]) + 10'(e1[ch*8 +: 8]) + 10'd1;
			end else begin
				cn2[ch] = {1'b0, e0[ch*8 +: 8], 1'b0} + 10'(e1[ch*8 +: 8]) + 10'd1;
			end
			cn3[ch] = 10'(e0[ch*8 +: 8]) + {1'b0, e1[ch*8 +: 8], 1'b0} + 10'd1;
		end
		for (int i = 0; i < 6; i++) begin
			if (six) begin
				an[i] = 11'(6 - i) * 11'(a0) + 11'(i + 1) * 11'(a1) + 11'd3;
			end else if (i < 4) begin
				an[i] = 11'(4 - i) * 11'(a0) + 11'(i + 1) * 11'(a1) + 11'd2;
			end else begin
				an[i] = 11'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fmt_s2     <= fmt_s1;
			cols_m1_s2 <= cols_m1_s1;
			rows_m1_s2 <= rows_m1_s1;
			lo_s2      <= lo_s1;
			codes_s2   <= cblk[63:32];
			e0_s2      <= e0;
			e1_s2      <= e1;
			three_s2   <= three;
			six_s2     <= six;
			cn2_s2     <= cn2;
			cn3_s2     <= cn3;
			an_s2      <= an;
		end
	end

	logic [19:0] p2_prod, p3_prod;
	logic [21:0] a6_prod;
	logic [20:0] a4_prod;

	always_comb begin
		p2_prod = '0;
		p3_prod = '0;
		a6_prod = '0;
		a4_prod = '0;
		job.fmt        = fmt_s2;
		job.cols_m1    = cols_m1_s2;
		job.rows_m1    = rows_m1_s2;
		job.codes      = codes_s2;
		job.alo        = lo_s2;
		job.transp3    = three_s2;
		job.pal_rgb[0] = e0_s2;
		job.pal_rgb[1] = e1_s2;
		for (int ch = 0; ch < 3; ch++) begin
			p2_prod = 20'(cn2_s2[ch]) * 20'd683;
			p3_prod = 20'(cn3_s2[ch]) * 20'd683;
			if (three_s2) begin
				job.pal_rgb[2][ch*8 +: 8] = cn2_s2[ch][8:1];
				job.pal_rgb[3][ch*8 +: 8] = 8'd0;
			end else begin
				job.pal_rgb[2][ch*8 +: 8] = p2_prod[18:11];
				job.pal_rgb[3][ch*8 +: 8] = p3_prod[18:11];
			end
		end
		job.atab[0] = lo_s2[7:0];
		job.atab[1] = lo_s2[15:8];
		for (int i = 0; i < 6; i++) begin
			a6_prod = 22'(an_s2[i]) * 22'd2341;
			a4_prod = 21'(an_s2[i]) * 21'd1639;
			if (six_s2) begin
				job.atab[i + 2] = a6_prod[21:14];
			end else if (i < 4) begin
				job.atab[i + 2] = a4_prod[20:13];
			end else if (i == 4) begin
				job.atab[i + 2] = 8'd0;
			end else begin
				job.atab[i + 2] = 8'd255;
			end
		end
	end

endmodule

// ----- rtl/dxt_queue.sv -----
// short job queue between front end and texel emitter
module dxt_queue
	import dxt_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  dxt_job_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output dxt_job_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	dxt_job_t      mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : AW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : AW'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/dxt_back.sv -----
// back end: walks the block texels and emits one decoded texel per cycle while a job is queued
module dxt_back
	import dxt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     empty,
	input  dxt_job_t head,
	output logic     pop,
	output logic     strobe,
	output dxt_out_t texel
);

	logic [1:0] r_q, c_q;
	logic       strobe_q;
	dxt_out_t   texel_q;

	logic [3:0] px;
	logic [1:0] idx;
	logic       is_last;
	logic [3:0] nib;
	logic [5:0] aidx;
	logic [7:0] alpha;
	logic [23:0] rgb;

	assign strobe = strobe_q;
	assign texel  = texel_q;

	always_comb begin
		px      = {r_q, c_q};
		idx     = head.codes[{px, 1'b0} +: 2];
		rgb     = head.pal_rgb[idx];
		is_last = (r_q == head.rows_m1) && (c_q == head.cols_m1);
		nib     = head.alo[{px, 2'b00} +: 4];
		aidx    = 6'd16 + 6'(px) * 6'd3;
		case (head.fmt)
			FMT_DXT1: begin
				alpha = (head.transp3 && idx == 2'd3) ? 8'd0 : 8'd255;
			end
			FMT_DXT3: begin
				alpha = {nib, nib};
			end
			FMT_DXT5: begin
				alpha = head.atab[head.alo[aidx +: 3]];
			end
			default: begin
				alpha = 8'd255;
			end
		endcase
		pop = !empty && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q      <= '0;
			c_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= !empty;
			if (!empty) begin
				if (is_last) begin
					r_q <= '0;
					c_q <= '0;
				end else if (c_q == head.cols_m1) begin
					r_q <= 2'(r_q + 2'd1);
					c_q <= '0;
				end else begin
					c_q <= 2'(c_q + 2'd1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!empty) begin
			texel_q.red       <= rgb[23:16];
			texel_q.green     <= rgb[15:8];
			texel_q.blue      <= rgb[7:0];
			texel_q.alpha_out <= alpha;
			texel_q.texel_row <= r_q;
			texel_q.texel_col <= c_q;
			texel_q.last      <= is_last;
		end
	end

endmodule

// ----- rtl/dxt_block_decoder.sv -----
// top level of the compressed texture block decoder
// A block is taken when start is high and busy is low; the format register (cfg_data, written
// through cfg_valid/cfg_ready, ready always high) selects DXT1, DXT3 or DXT5 for blocks taken
// after the write. The in-range texels come out row by row, one per cycle, each marked by strobe
// for a single cycle, with last on the final one; the receiver cannot stall them. A taken block passes
// the front stages and the job queue before its first texel is registered at the output. The texel
// emitter sets throughput: it gives one texel per in-range texel, and queued blocks follow each other
// with no gap. Front stages and a job queue (QUEUE_DEPTH entries, two by default) let new blocks be
// taken while earlier ones are still emitting; busy rises only when all of them are occupied. Blocks
// with format code 3 or a zero column or row count are taken and give no texels.
module dxt_block_decoder
	import dxt_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  dxt_in_t    blk,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	output logic       strobe,
	output dxt_out_t   texel
);

	logic     push, q_full, q_empty, pop;
	dxt_job_t job, head;

	dxt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.blk       (blk),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.job       (job),
		.q_full    (q_full)
	);

	dxt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (job),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	dxt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.head   (head),
		.pop    (pop),
		.strobe (strobe),
		.texel  (texel)
	);

endmodule

// ----- rtl/dxt_checker.sv -----
// port-level checks on the texel output sequence, bound to the top level
module dxt_checker
	import dxt_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     strobe,
	input dxt_out_t texel
);

	a_block_continuous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !texel.last |=> strobe)
		else $error("texel beat missing inside a block");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !texel.last |=>
		(texel.texel_row == $past(texel.texel_row) &&
		 texel.texel_col == 2'($past(texel.texel_col) + 2'd1)) ||
		(texel.texel_row == 2'($past(texel.texel_row) + 2'd1) && texel.texel_col == 2'd0))
		else $error("texel beat out of scan order");

	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && texel.last |=> !strobe || (texel.texel_row == 2'd0 && texel.texel_col == 2'd0))
		else $error("new block does not start at the first texel");

endmodule

bind dxt_block_decoder dxt_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.strobe (strobe),
	.texel  (texel)
);
